// ===== design/chm_pkg.sv =====
`default_nettype none
package chm_pkg;

	localparam int BUCKETS_DEF    = 32;
	localparam int CAPACITY_DEF   = 64;
	localparam int KEY_BYTES_DEF  = 8;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [63:0] HASH_SEED = 64'd5381;

	typedef enum logic [1:0] {
		REQ_PUT    = 2'd0,
		REQ_GET    = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FOUND    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		CS_INIT,
		CS_IDLE,
		CS_HASH,
		CS_HEAD_RD,
		CS_HEAD_WT,
		CS_WALK,
		CS_CMP,
		CS_ALLOC_RD,
		CS_ALLOC,
		CS_LINK,
		CS_UNLINK,
		CS_FREE,
		CS_DONE
	} ctl_state_t;

	typedef enum logic [2:0] {
		HP_IDLE,
		HP_BYTES,
		HP_FOLD,
		HP_QUOT,
		HP_REM
	} hash_phase_t;

endpackage
`default_nettype wire

// ===== design/chained_hash_map_engine_unit.sv =====
`default_nettype none
// Channel | Handshake             | Payload
// --------+-----------------------+------------------------------
// request | in_valid / in_stall   | req_type, key, value
// result  | out_valid / out_stall | status, value_out, item_count
// config  | cfg_we                | cfg_wdata (key_bytes)
//
// One request at a time: in_stall stays high until the engine is idle again.
// A transaction steps through accept, hashing of the key bytes (then fold, quotient and
// remainder), the bucket head read, a compare per chain entry, the end of a chain on a
// miss, the insert or remove writes, and the load of the result register.
// After reset a clearing pass over max(BUCKETS, CAPACITY) entries builds the bucket
// table and the free list with in_stall high. A stalled result holds the next in DONE.
module chained_hash_map_engine_unit #(
	parameter int BUCKETS    = chm_pkg::BUCKETS_DEF,
	parameter int CAPACITY   = chm_pkg::CAPACITY_DEF,
	parameter int KEY_BYTES  = chm_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS = chm_pkg::VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] key,
	input  wire logic [31:0] value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [31:0]      value_out,
	output logic [6:0]       item_count
);
	import chm_pkg::*;

	localparam int BW    = $clog2(BUCKETS);
	localparam int IW    = $clog2(CAPACITY);
	localparam int LW    = $clog2(CAPACITY + 1);
	localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int DEPTH = (BUCKETS > CAPACITY) ? BUCKETS : CAPACITY;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	// storage
	logic [LW-1:0] head_mem [BUCKETS];
	logic [63:0]   key_mem  [CAPACITY];
	logic [VW-1:0] val_mem  [CAPACITY];
	logic [LW-1:0] next_mem [CAPACITY];

	logic          head_we, key_we, val_we, next_we;
	logic [BW-1:0] head_wa;
	logic [LW-1:0] head_wd, next_wd;
	logic [IW-1:0] ent_wa, next_wa, ent_ra;
	logic [63:0]   key_wd;
	logic [VW-1:0] val_wd;
	logic [LW-1:0] head_rd, next_rd;
	logic [63:0]   key_rd;
	logic [VW-1:0] val_rd;

	ctl_state_t    state_q, state_d;
	logic [3:0]    kbytes_q;
	logic [3:0]    nb;
	logic [63:0]   km;
	req_t          req_q;
	logic [63:0]   key_q;
	logic [VW-1:0] val_q;
	logic [BW-1:0] bucket_q;
	logic [LW-1:0] cur_q, prev_q, ncur_q, alloc_q, free_head_q, total_q;
	logic [CW-1:0] init_q;
	status_t       res_status_q;
	logic [31:0]   res_value_q;
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [31:0]   value_out_q;
	logic [6:0]    item_count_q;

	logic          accept, hit, load_out;
	logic          h_done;
	logic [BW-1:0] h_bucket;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != CS_IDLE);
	assign load_out = (state_q == CS_DONE) && (!out_valid_q || !out_stall);

	// effective key width and compare mask
	always_comb begin
		nb = kbytes_q;
		if (kbytes_q == 4'd0) nb = 4'd1;
		else if (kbytes_q > 4'd8) nb = 4'd8;
		for (int j = 0; j < 8; j++) km[8*j +: 8] = (4'(j) < nb) ? 8'hFF : 8'h00;
	end

	assign hit = ((key_rd ^ key_q) & km) == 64'd0;

	chm_hash_unit #(.BUCKETS(BUCKETS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (key),
		.nbytes (nb),
		.done   (h_done),
		.bucket (h_bucket)
	);

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd <= head_mem[bucket_q];
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[ent_wa] <= key_wd;
		if (val_we) val_mem[ent_wa] <= val_wd;
		if (next_we) next_mem[next_wa] <= next_wd;
		key_rd  <= key_mem[ent_ra];
		val_rd  <= val_mem[ent_ra];
		next_rd <= next_mem[ent_ra];
	end

	assign ent_ra = (state_q == CS_ALLOC_RD) ? free_head_q[IW-1:0] : cur_q[IW-1:0];

	// next state and memory strobes
	always_comb begin
		state_d = state_q;
		head_we = 1'b0;
		head_wa = bucket_q;
		head_wd = NIL;
		key_we  = 1'b0;
		val_we  = 1'b0;
		ent_wa  = cur_q[IW-1:0];
		key_wd  = key_q;
		val_wd  = val_q;
		next_we = 1'b0;
		next_wa = cur_q[IW-1:0];
		next_wd = NIL;
		case (state_q)
			CS_INIT: begin
				head_we = (init_q < CW'(BUCKETS));
				head_wa = init_q[BW-1:0];
				head_wd = NIL;
				next_we = (init_q < CW'(CAPACITY));
				next_wa = init_q[IW-1:0];
				next_wd = (init_q + CW'(1) >= CW'(CAPACITY)) ? NIL : LW'(init_q + CW'(1));
				if (init_q == CW'(DEPTH - 1)) state_d = CS_IDLE;
			end
			CS_IDLE:    if (accept) state_d = CS_HASH;
			CS_HASH:    if (h_done) state_d = CS_HEAD_RD;
			CS_HEAD_RD: state_d = CS_HEAD_WT;
			CS_HEAD_WT: state_d = CS_WALK;
			CS_WALK: begin
				if (cur_q != NIL) state_d = CS_CMP;
				else if (req_q == REQ_PUT && free_head_q != NIL) state_d = CS_ALLOC_RD;
				else state_d = CS_DONE;
			end
			CS_CMP: begin
				if (!hit) state_d = CS_WALK;
				else if (req_q == REQ_REMOVE) state_d = CS_UNLINK;
				else begin
					state_d = CS_DONE;
					val_we  = (req_q == REQ_PUT);
				end
			end
			CS_ALLOC_RD: state_d = CS_ALLOC;
			CS_ALLOC: begin
				ent_wa  = free_head_q[IW-1:0];
				key_we  = 1'b1;
				val_we  = 1'b1;
				next_we = 1'b1;
				next_wa = free_head_q[IW-1:0];
				next_wd = NIL;
				state_d = CS_LINK;
			end
			CS_LINK: begin
				next_we = (prev_q != NIL);
				next_wa = prev_q[IW-1:0];
				next_wd = alloc_q;
				head_we = (prev_q == NIL);
				head_wd = alloc_q;
				state_d = CS_DONE;
			end
			CS_UNLINK: begin
				next_we = (prev_q != NIL);
				next_wa = prev_q[IW-1:0];
				next_wd = ncur_q;
				head_we = (prev_q == NIL);
				head_wd = ncur_q;
				state_d = CS_FREE;
			end
			CS_FREE: begin
				next_we = 1'b1;
				next_wa = cur_q[IW-1:0];
				next_wd = free_head_q;
				state_d = CS_DONE;
			end
			CS_DONE: if (load_out) state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_INIT;
			init_q      <= '0;
			kbytes_q    <= 4'(KEY_BYTES);
			free_head_q <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == CS_INIT) init_q <= init_q + CW'(1);
			if (cfg_we) kbytes_q <= cfg_wdata;
			if (state_q == CS_ALLOC) free_head_q <= next_rd;
			if (state_q == CS_FREE) free_head_q <= cur_q;
			if (state_q == CS_LINK) total_q <= total_q + LW'(1);
			if (state_q == CS_FREE && total_q != '0) total_q <= total_q - LW'(1);
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(req_type);
			key_q <= key;
			val_q <= value[VW-1:0];
		end
		if (h_done && state_q == CS_HASH) bucket_q <= h_bucket;
		case (state_q)
			CS_HEAD_WT: begin
				cur_q  <= head_rd;
				prev_q <= NIL;
			end
			CS_WALK: begin
				res_value_q  <= '0;
				res_status_q <= (req_q == REQ_PUT) ? ST_FULL : ST_NOTFOUND;
			end
			CS_CMP: begin
				if (!hit) begin
					prev_q <= cur_q;
					cur_q  <= next_rd;
				end else begin
					ncur_q <= next_rd;
					case (req_q)
						REQ_PUT: begin
							res_status_q <= ST_UPDATED;
							res_value_q  <= '0;
						end
						REQ_GET, REQ_REMOVE: begin
							res_status_q <= ST_FOUND;
							res_value_q  <= 32'(val_rd);
						end
						default: begin
							res_status_q <= ST_NOTFOUND;
							res_value_q  <= '0;
						end
					endcase
				end
			end
			CS_ALLOC: alloc_q <= free_head_q;
			CS_LINK:  res_status_q <= ST_INSERTED;
			default:  cur_q <= cur_q;
		endcase
		if (load_out) begin
			status_q     <= res_status_q;
			value_out_q  <= res_value_q;
			item_count_q <= 7'(total_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign value_out  = value_out_q;
	assign item_count = item_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= LW'(CAPACITY))
		else $error("entry count above pool size");

	a_accept_hash: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == CS_HASH)
		else $error("accepted transaction did not start hashing");

	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CS_ALLOC_RD |-> free_head_q != NIL)
		else $error("allocation from an empty free list");

	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CS_FREE |-> total_q != '0)
		else $error("remove with zero entries held");

endmodule
`default_nettype wire

// ===== design/chm_hash_unit.sv =====
`default_nettype none
module chm_hash_unit #(
	parameter int BUCKETS = chm_pkg::BUCKETS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [63:0]                key,
	input  wire logic [3:0]                 nbytes,
	output logic                            done,
	output logic [$clog2(BUCKETS)-1:0]      bucket
);
	import chm_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	// 2^(16*i) mod BUCKETS, folds the hash in 16-bit chunks
	localparam logic [31:0] K1 = 32'((64'd1 << 16) % 64'(BUCKETS));
	localparam logic [31:0] K2 = 32'((64'd1 << 32) % 64'(BUCKETS));
	localparam logic [31:0] K3 = 32'((64'd1 << 48) % 64'(BUCKETS));
	// floor(2^32 / BUCKETS); the quotient estimate is low by at most one
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));
	localparam logic [31:0] NB32  = 32'(BUCKETS);

	hash_phase_t     phase_q, phase_d;
	logic [63:0]     h_q;
	logic [63:0]     kshift_q;
	logic [3:0]      cnt_q;
	logic [31:0]     fold_q, quot_q, rem_q;
	logic [31:0]     fold_d, quot_d;
	logic            done_q;

	// folded value stays below 2^30
	assign fold_d = {16'd0, h_q[15:0]} + 32'(h_q[31:16]) * K1
		+ 32'(h_q[47:32]) * K2 + 32'(h_q[63:48]) * K3;
	assign quot_d = 32'(({32'd0, fold_q} * {32'd0, RECIP}) >> 32);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			HP_IDLE:  if (start) phase_d = HP_BYTES;
			HP_BYTES: if (cnt_q == 4'(nbytes - 4'd1)) phase_d = HP_FOLD;
			HP_FOLD:  phase_d = HP_QUOT;
			HP_QUOT:  phase_d = HP_REM;
			HP_REM:   phase_d = HP_IDLE;
			default:  phase_d = HP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HP_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == HP_REM);
			cnt_q   <= (phase_q == HP_BYTES) ? cnt_q + 4'd1 : 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			HP_IDLE: begin
				h_q      <= HASH_SEED;
				kshift_q <= key;
			end
			HP_BYTES: begin
				h_q      <= (h_q << 5) + h_q + {56'd0, kshift_q[7:0]};
				kshift_q <= kshift_q >> 8;
			end
			HP_FOLD: fold_q <= fold_d;
			HP_QUOT: quot_q <= quot_d;
			// remainder lands in [0, 2*BUCKETS)
			HP_REM:  rem_q  <= fold_q - quot_q * NB32;
			default: h_q <= h_q;
		endcase
	end

	assign done   = done_q;
	assign bucket = BW'((rem_q >= NB32) ? rem_q - NB32 : rem_q);

endmodule
`default_nettype wire
